@@ design/dtlv_pkg.sv @@
package dtlv_pkg;

   // DER length octet fields
   localparam logic [7:0] LONG_FORM_MASK = 8'h80;
   localparam logic [7:0] COUNT_MASK     = 8'h7f;
   localparam int unsigned MAX_LEN_BYTES = 4;

   // byte_kind codes
   localparam logic [2:0] KIND_TAG     = 3'd0;
   localparam logic [2:0] KIND_LENGTH  = 3'd1;
   localparam logic [2:0] KIND_CONTENT = 3'd2;
   localparam logic [2:0] KIND_ERROR   = 3'd3;
   localparam logic [2:0] KIND_BEYOND  = 3'd4;

   // error_cause codes
   localparam logic [1:0] CAUSE_NONE    = 2'd0;
   localparam logic [1:0] CAUSE_ROOM    = 2'd1;
   localparam logic [1:0] CAUSE_COUNT   = 2'd2;
   localparam logic [1:0] CAUSE_OVERRUN = 2'd3;

   typedef enum logic [4:0] {
      PH_TAG     = 5'b00001,
      PH_LEN1    = 5'b00010,
      PH_LENX    = 5'b00100,
      PH_CONTENT = 5'b01000,
      PH_STOPPED = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       region_start;
   } item_type;

   typedef struct packed {
      logic [2:0]  byte_kind;
      logic [7:0]  tag_value;
      logic [15:0] declared_length;
      logic [7:0]  content_byte;
      logic [15:0] content_offset;
      logic        header_done;
      logic        element_last;
      logic [1:0]  error_cause;
   } result_type;

endpackage

@@ design/dtlv_req_if.sv @@
interface dtlv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       region_start;

   modport source (output valid, output data_byte, output region_start, input ready);
   modport sink   (input valid, input data_byte, input region_start, output ready);
endinterface

@@ design/dtlv_rsp_if.sv @@
interface dtlv_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  byte_kind;
   logic [7:0]  tag_value;
   logic [15:0] declared_length;
   logic [7:0]  content_byte;
   logic [15:0] content_offset;
   logic        header_done;
   logic        element_last;
   logic [1:0]  error_cause;

   modport source (output valid, output byte_kind, output tag_value, output declared_length,
                   output content_byte, output content_offset, output header_done,
                   output element_last, output error_cause, input ready);
   modport sink   (input valid, input byte_kind, input tag_value, input declared_length,
                   input content_byte, input content_offset, input header_done,
                   input element_last, input error_cause, output ready);
endinterface

@@ design/dtlv_in_stage.sv @@
module dtlv_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  dtlv_pkg::item_type in_item,
   input  logic               out_free,
   output logic               advance,
   output dtlv_pkg::item_type item
);

   logic               valid_ff;
   logic               valid_in;
   dtlv_pkg::item_type item_ff;

   assign advance  = valid_ff && out_free;
   assign in_ready = !valid_ff || out_free;
   assign item     = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

@@ design/dtlv_parse_core.sv @@
module dtlv_parse_core #(
   parameter int unsigned REGION_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  dtlv_pkg::item_type   item,
   input  logic [15:0]          region_length,
   output dtlv_pkg::result_type result
);

   localparam int unsigned SW = ((REGION_WIDTH > 32) ? REGION_WIDTH : 32) + 2;
   localparam logic [REGION_WIDTH-1:0] POS_MAX = {REGION_WIDTH{1'b1}};

   dtlv_pkg::phase_type     phase_ff, phase_in, cur_phase;
   logic [REGION_WIDTH-1:0] pos_ff, pos_in, p;
   logic [7:0]              tag_ff, tag_in, cur_tag;
   logic [31:0]             acc_ff, acc_in, cur_acc;
   logic [2:0]              left_ff, left_in, cur_left;
   logic [15:0]             rem_ff, rem_in, cur_rem;

   logic [7:0]  b;
   logic [6:0]  n;
   logic [SW-1:0] p_w, rl_w;
   logic        beyond, tag_short, count_bad, lenx_over, fin_over, finish;
   logic [31:0] acc_shift, fin_len;
   logic [15:0] rem_dec;

   assign b = item.data_byte;
   assign n = b[6:0] & dtlv_pkg::COUNT_MASK[6:0];

   always_comb begin
      // a region start clears the parse before this byte is handled
      cur_phase = item.region_start ? dtlv_pkg::PH_TAG : phase_ff;
      p         = item.region_start ? '0 : pos_ff;
      cur_tag   = item.region_start ? '0 : tag_ff;
      cur_acc   = item.region_start ? '0 : acc_ff;
      cur_left  = item.region_start ? '0 : left_ff;
      cur_rem   = item.region_start ? '0 : rem_ff;

      p_w       = SW'(p);
      rl_w      = SW'(region_length);
      beyond    = p_w >= rl_w;
      tag_short = (p_w + SW'(2)) > rl_w;
      count_bad = (n == 7'd0) || (n > 7'(dtlv_pkg::MAX_LEN_BYTES));
      lenx_over = (p_w + SW'(1) + SW'(n)) > rl_w;
      acc_shift = {cur_acc[23:0], b};
      fin_len   = (cur_phase == dtlv_pkg::PH_LEN1) ? {24'd0, b} : acc_shift;
      fin_over  = (p_w + SW'(1) + SW'(fin_len)) > rl_w;
      rem_dec   = (cur_rem != 16'd0) ? cur_rem - 16'd1 : cur_rem;

      phase_in = cur_phase;
      pos_in   = (p != POS_MAX) ? p + REGION_WIDTH'(1) : p;
      tag_in   = cur_tag;
      acc_in   = cur_acc;
      left_in  = cur_left;
      rem_in   = cur_rem;
      finish   = 1'b0;
      result   = '0;

      if (cur_phase == dtlv_pkg::PH_STOPPED) begin
         result.byte_kind = dtlv_pkg::KIND_ERROR;
      end else if (beyond) begin
         // past the region: report and keep the parse state; the position still advances
         result.byte_kind = dtlv_pkg::KIND_BEYOND;
      end else begin
         unique case (cur_phase)
            dtlv_pkg::PH_TAG: begin
               if (tag_short) begin
                  phase_in           = dtlv_pkg::PH_STOPPED;
                  result.byte_kind   = dtlv_pkg::KIND_ERROR;
                  result.error_cause = dtlv_pkg::CAUSE_ROOM;
               end else begin
                  tag_in           = b;
                  acc_in           = '0;
                  rem_in           = '0;
                  left_in          = '0;
                  result.byte_kind = dtlv_pkg::KIND_TAG;
                  result.tag_value = b;
                  phase_in         = dtlv_pkg::PH_LEN1;
               end
            end
            dtlv_pkg::PH_LEN1: begin
               result.byte_kind = dtlv_pkg::KIND_LENGTH;
               result.tag_value = cur_tag;
               if ((b & dtlv_pkg::LONG_FORM_MASK) != 8'd0) begin
                  if (count_bad) begin
                     phase_in           = dtlv_pkg::PH_STOPPED;
                     result.byte_kind   = dtlv_pkg::KIND_ERROR;
                     result.tag_value   = '0;
                     result.error_cause = dtlv_pkg::CAUSE_COUNT;
                  end else if (lenx_over) begin
                     phase_in           = dtlv_pkg::PH_STOPPED;
                     result.byte_kind   = dtlv_pkg::KIND_ERROR;
                     result.tag_value   = '0;
                     result.error_cause = dtlv_pkg::CAUSE_OVERRUN;
                  end else begin
                     acc_in   = '0;
                     left_in  = n[2:0];
                     phase_in = dtlv_pkg::PH_LENX;
                  end
               end else begin
                  finish = 1'b1;
               end
            end
            dtlv_pkg::PH_LENX: begin
               result.byte_kind = dtlv_pkg::KIND_LENGTH;
               result.tag_value = cur_tag;
               acc_in           = acc_shift;
               left_in          = (cur_left != 3'd0) ? cur_left - 3'd1 : cur_left;
               finish           = (left_in == 3'd0);
            end
            dtlv_pkg::PH_CONTENT: begin
               result.byte_kind       = dtlv_pkg::KIND_CONTENT;
               result.tag_value       = cur_tag;
               result.declared_length = cur_acc[15:0];
               result.content_byte    = b;
               result.content_offset  = cur_acc[15:0] - cur_rem;
               rem_in                 = rem_dec;
               if (rem_dec == 16'd0) begin
                  result.element_last = 1'b1;
                  phase_in            = dtlv_pkg::PH_TAG;
               end
            end
            default: begin
               phase_in         = dtlv_pkg::PH_STOPPED;
               result.byte_kind = dtlv_pkg::KIND_ERROR;
            end
         endcase

         if (finish) begin
            if (fin_over) begin
               phase_in           = dtlv_pkg::PH_STOPPED;
               result.byte_kind   = dtlv_pkg::KIND_ERROR;
               result.tag_value   = '0;
               result.error_cause = dtlv_pkg::CAUSE_OVERRUN;
            end else begin
               acc_in                 = fin_len;
               result.declared_length = fin_len[15:0];
               result.header_done     = 1'b1;
               if (fin_len == 32'd0) begin
                  result.element_last = 1'b1;
                  phase_in            = dtlv_pkg::PH_TAG;
               end else begin
                  rem_in   = fin_len[15:0];
                  phase_in = dtlv_pkg::PH_CONTENT;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dtlv_pkg::PH_TAG;
         pos_ff   <= '0;
         tag_ff   <= '0;
         acc_ff   <= '0;
         left_ff  <= '0;
         rem_ff   <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         tag_ff   <= tag_in;
         acc_ff   <= acc_in;
         left_ff  <= left_in;
         rem_ff   <= rem_in;
      end
   end

endmodule

@@ design/dtlv_out_stage.sv @@
module dtlv_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  dtlv_pkg::result_type result,
   input  logic                 out_ready,
   output logic                 out_valid,
   output logic                 out_free,
   output dtlv_pkg::result_type out_result
);

   logic                 valid_ff;
   logic                 valid_in;
   dtlv_pkg::result_type result_ff;

   assign out_free   = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

endmodule

@@ design/der_tlv_header_parser.sv @@
// channel   direction  contents
// req_chan  in         data_byte, region_start            (valid/ready)
// rsp_chan  out        one classified result per byte     (valid/ready)
// csr_*     in         region_length write, no read-back
//
// One byte per cycle sustained while rsp_chan is ready; each byte is classified in the
// cycle it leaves the input register and its result appears in the cycle after that.
// The rate is set by the single parse-state update per byte in dtlv_parse_core.
// Reset clears the parse state, both stage valids and region_length.
// A stalled result holds in the output register while the input register still
// takes one more byte; req_chan.ready drops only when both are full.
module der_tlv_header_parser #(
   parameter int unsigned REGION_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   dtlv_req_if.sink    req_chan,
   dtlv_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic [15:0]          region_length_ff;
   logic                 advance;
   logic                 out_free;
   dtlv_pkg::item_type   in_item;
   dtlv_pkg::item_type   item;
   dtlv_pkg::result_type result;
   dtlv_pkg::result_type out_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_length_ff <= '0;
      end else if (csr_wr_en) begin
         region_length_ff <= csr_wr_data;
      end
   end

   assign in_item.data_byte    = req_chan.data_byte;
   assign in_item.region_start = req_chan.region_start;

   dtlv_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .in_ready (req_chan.ready),
      .in_item  (in_item),
      .out_free (out_free),
      .advance  (advance),
      .item     (item)
   );

   dtlv_parse_core #(
      .REGION_WIDTH (REGION_WIDTH)
   ) u_parse_core (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .item          (item),
      .region_length (region_length_ff),
      .result        (result)
   );

   dtlv_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .result     (result),
      .out_ready  (rsp_chan.ready),
      .out_valid  (rsp_chan.valid),
      .out_free   (out_free),
      .out_result (out_result)
   );

   assign rsp_chan.byte_kind       = out_result.byte_kind;
   assign rsp_chan.tag_value       = out_result.tag_value;
   assign rsp_chan.declared_length = out_result.declared_length;
   assign rsp_chan.content_byte    = out_result.content_byte;
   assign rsp_chan.content_offset  = out_result.content_offset;
   assign rsp_chan.header_done     = out_result.header_done;
   assign rsp_chan.element_last    = out_result.element_last;
   assign rsp_chan.error_cause     = out_result.error_cause;

`ifndef ASSERT_OFF
   // a cause is only ever reported on an error result
   a_cause_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.error_cause != dtlv_pkg::CAUSE_NONE
      |-> rsp_chan.byte_kind == dtlv_pkg::KIND_ERROR)
      else $error("error cause on a non-error result");

   // errors and stopped bytes never complete a header or an element and carry no tag
   a_error_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.byte_kind == dtlv_pkg::KIND_ERROR
      |-> !rsp_chan.header_done && !rsp_chan.element_last && rsp_chan.tag_value == 8'd0)
      else $error("error result carries header or element flags");

   // content offset stays inside the declared contents and no header completes there
   a_offset_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.byte_kind == dtlv_pkg::KIND_CONTENT
      |-> rsp_chan.content_offset < rsp_chan.declared_length && !rsp_chan.header_done)
      else $error("content offset outside declared length");

   // a stalled result is never overwritten by the next transfer
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |-> !advance)
      else $error("result register loaded while stalled");
`endif

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
   import dtlv_pkg::*;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   dtlv_req_if req_chan ();
   dtlv_rsp_if rsp_chan ();

   der_tlv_header_parser uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // parser state as the testbench sees it
   phase_type   parse_ph;
   logic [15:0] byte_pos;
   logic [7:0]  elem_tag;
   logic [31:0] len_acc;
   logic [2:0]  len_left;
   logic [31:0] content_left;
   logic [15:0] region_len;

   item_type    pending_bytes[$];
   result_type  expected_results[$];
   logic [7:0]  region_bytes[$];
   int          fail_count   = 0;
   int          result_count = 0;
   int          queued_count = 0;
   bit          steady_flow  = 1'b0;

   function automatic void restart_parse();
      parse_ph     = PH_TAG;
      byte_pos     = '0;
      elem_tag     = '0;
      len_acc      = '0;
      len_left     = '0;
      content_left = '0;
   endfunction

   // complete the length field; contents must fit inside the region
   function automatic void close_header(input logic [31:0] len, input logic [15:0] p,
                                        inout result_type r);
      if (34'(p) + 34'd1 + 34'(len) > 34'(region_len)) begin
         parse_ph      = PH_STOPPED;
         r.byte_kind   = KIND_ERROR;
         r.tag_value   = '0;
         r.error_cause = CAUSE_OVERRUN;
      end else begin
         len_acc           = len;
         r.declared_length = len[15:0];
         r.header_done     = 1'b1;
         if (len == 0) begin
            r.element_last = 1'b1;
            parse_ph       = PH_TAG;
         end else begin
            content_left = len;
            parse_ph     = PH_CONTENT;
         end
      end
   endfunction

   function automatic result_type classify_byte(input logic [7:0] b, input logic start);
      result_type  r;
      logic [15:0] p;
      logic [7:0]  count;
      logic [31:0] offset;
      r = '0;
      if (start)
         restart_parse();
      p = byte_pos;
      if (byte_pos != 16'hffff)
         byte_pos = byte_pos + 16'd1;
      if (parse_ph == PH_STOPPED) begin
         r.byte_kind = KIND_ERROR;
         return r;
      end
      if (p >= region_len) begin
         r.byte_kind = KIND_BEYOND;
         return r;
      end
      case (parse_ph)
         PH_TAG: begin
            if (18'(p) + 18'd2 > 18'(region_len)) begin
               parse_ph      = PH_STOPPED;
               r.byte_kind   = KIND_ERROR;
               r.error_cause = CAUSE_ROOM;
            end else begin
               elem_tag     = b;
               len_acc      = '0;
               content_left = '0;
               len_left     = '0;
               r.byte_kind  = KIND_TAG;
               r.tag_value  = b;
               parse_ph     = PH_LEN1;
            end
         end
         PH_LEN1: begin
            r.byte_kind = KIND_LENGTH;
            r.tag_value = elem_tag;
            if ((b & LONG_FORM_MASK) != 0) begin
               count = b & COUNT_MASK;
               if (count == 0 || count > 8'(MAX_LEN_BYTES)) begin
                  parse_ph      = PH_STOPPED;
                  r.byte_kind   = KIND_ERROR;
                  r.tag_value   = '0;
                  r.error_cause = CAUSE_COUNT;
               end else if (18'(p) + 18'd1 + 18'(count) > 18'(region_len)) begin
                  parse_ph      = PH_STOPPED;
                  r.byte_kind   = KIND_ERROR;
                  r.tag_value   = '0;
                  r.error_cause = CAUSE_OVERRUN;
               end else begin
                  len_acc  = '0;
                  len_left = count[2:0];
                  parse_ph = PH_LENX;
               end
            end else begin
               close_header({24'd0, b}, p, r);
            end
         end
         PH_LENX: begin
            r.byte_kind = KIND_LENGTH;
            r.tag_value = elem_tag;
            len_acc     = {len_acc[23:0], b};
            if (len_left != 0)
               len_left = len_left - 3'd1;
            if (len_left == 0)
               close_header(len_acc, p, r);
         end
         PH_CONTENT: begin
            offset            = len_acc - content_left;
            r.byte_kind       = KIND_CONTENT;
            r.tag_value       = elem_tag;
            r.declared_length = len_acc[15:0];
            r.content_byte    = b;
            r.content_offset  = offset[15:0];
            if (content_left != 0)
               content_left = content_left - 32'd1;
            if (content_left == 0) begin
               r.element_last = 1'b1;
               parse_ph       = PH_TAG;
            end
         end
         default: begin
            parse_ph    = PH_STOPPED;
            r.byte_kind = KIND_ERROR;
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      fail_count++;
      if (fail_count <= 40)
         $display("%0t ns, result %0d: %s", $time, result_count, what);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   // driver: offer the next byte when the slot is free, idling at random unless steady_flow
   always @(posedge clock) begin : byte_driver
      item_type next_item;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            expected_results.push_back(classify_byte(req_chan.data_byte,
                                                     req_chan.region_start));
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_bytes.size() != 0 && (steady_flow || $urandom_range(99) >= 28)) begin
               next_item              = pending_bytes.pop_front();
               req_chan.valid        <= 1'b1;
               req_chan.data_byte    <= next_item.data_byte;
               req_chan.region_start <= next_item.region_start;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each transfer with the oldest expectation
   always @(posedge clock) begin : result_monitor
      result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            result_count++;
            if (expected_results.size() == 0) begin
               report_mismatch("result arrived with nothing expected");
            end else begin
               want = expected_results.pop_front();
               check_field("byte_kind", 16'(rsp_chan.byte_kind), 16'(want.byte_kind));
               check_field("tag_value", 16'(rsp_chan.tag_value), 16'(want.tag_value));
               check_field("declared_length", rsp_chan.declared_length,
                           want.declared_length);
               check_field("content_byte", 16'(rsp_chan.content_byte),
                           16'(want.content_byte));
               check_field("content_offset", rsp_chan.content_offset, want.content_offset);
               check_field("header_done", 16'(rsp_chan.header_done),
                           16'(want.header_done));
               check_field("element_last", 16'(rsp_chan.element_last),
                           16'(want.element_last));
               check_field("error_cause", 16'(rsp_chan.error_cause),
                           16'(want.error_cause));
            end
         end
         rsp_chan.ready <= steady_flow || ($urandom_range(99) >= 28);
      end
   end

   task automatic send(input logic [7:0] b, input logic start);
      item_type it;
      it.data_byte    = b;
      it.region_start = start;
      pending_bytes.push_back(it);
      queued_count++;
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_bytes.size() != 0 || req_chan.valid || expected_results.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_region_length(input logic [15:0] value);
      wait_idle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      region_len   = value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // fill region_bytes with well-formed elements; a leftover byte gives a short header
   task automatic build_region(input int size);
      int room, nbytes, cap, len;
      region_bytes.delete();
      while (size - region_bytes.size() >= 2) begin
         room   = size - region_bytes.size() - 2;
         nbytes = 0;
         if ($urandom_range(1) == 1 && room >= 1)
            nbytes = $urandom_range(1, (room < 4) ? room : 4);
         cap = room - nbytes;
         if (nbytes == 0 && cap > 127)
            cap = 127;
         if (nbytes == 1 && cap > 255)
            cap = 255;
         if (cap > 12 && $urandom_range(2) != 0)
            cap = 12;
         len = $urandom_range(0, cap);
         region_bytes.push_back(8'($urandom_range(255)));
         if (nbytes == 0) begin
            region_bytes.push_back(8'(len));
         end else begin
            region_bytes.push_back(LONG_FORM_MASK | 8'(nbytes));
            for (int i = nbytes - 1; i >= 0; i--)
               region_bytes.push_back(8'(len >> (8 * i)));
         end
         repeat (len) region_bytes.push_back(8'($urandom_range(255)));
      end
      if (region_bytes.size() < size)
         region_bytes.push_back(8'($urandom_range(255)));
   endtask

   task automatic send_region_bytes(input int first, input int last);
      for (int i = first; i <= last; i++)
         send(region_bytes[i], i == 0);
   endtask

   initial begin : stimulus
      int sel, size, split, count;
      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_wr_data           = '0;
      req_chan.valid        = 1'b0;
      req_chan.data_byte    = '0;
      req_chan.region_start = 1'b0;
      rsp_chan.ready        = 1'b0;
      region_len            = '0;
      restart_parse();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty region, then a region holding an empty element, a long-form one,
      // an overrun and a stopped byte
      write_region_length(16'd0);
      send(8'hff, 1'b1);
      write_region_length(16'd12);
      send(8'h30, 1'b1); send(8'h00, 1'b0);
      send(8'h04, 1'b0); send(8'h81, 1'b0); send(8'h02, 1'b0);
      send(8'hff, 1'b0); send(8'h00, 1'b0);
      send(8'hff, 1'b0); send(8'h7f, 1'b0); send(8'h00, 1'b0);
      // long-form count of zero and of five
      send(8'h02, 1'b1); send(8'h80, 1'b0);
      send(8'h02, 1'b1); send(8'h85, 1'b0);
      // length bytes past the region end; tag with no room for a header
      write_region_length(16'd3);
      send(8'h02, 1'b1); send(8'h82, 1'b0);
      send(8'h05, 1'b1); send(8'h00, 1'b0); send(8'h31, 1'b0);
      // four-byte length of 2^31
      write_region_length(16'hffff);
      send(8'ha0, 1'b1); send(8'h84, 1'b0);
      send(8'h80, 1'b0); send(8'h00, 1'b0); send(8'h00, 1'b0); send(8'h00, 1'b0);
      // shrink the region under an open element, then widen it again
      write_region_length(16'd4);
      send(8'h01, 1'b1); send(8'h01, 1'b0);
      write_region_length(16'd2);
      send(8'haa, 1'b0);
      write_region_length(16'd8);
      send(8'h55, 1'b0);

      // a long element with no idling on either side, then an empty one
      write_region_length(16'hffff);
      steady_flow = 1'b1;
      send(8'h04, 1'b1); send(8'h82, 1'b0); send(8'h00, 1'b0); send(8'hc8, 1'b0);
      repeat (200) send(8'($urandom_range(255)), 1'b0);
      send(8'h05, 1'b0); send(8'h00, 1'b0);
      repeat (6) send(8'($urandom_range(255)), 1'b0);
      wait_idle();
      steady_flow = 1'b0;

      while (queued_count < 900) begin
         sel = $urandom_range(99);
         if (sel < 70) begin
            size = ($urandom_range(19) == 0) ? $urandom_range(200, 600) : $urandom_range(2, 40);
            build_region(size);
            if ($urandom_range(3) == 0)
               region_bytes[$urandom_range(size - 1)] ^= 8'(1 << $urandom_range(7));
            write_region_length(($urandom_range(5) == 0) ? 16'($urandom_range(size + 3))
                                                         : 16'(size));
            send_region_bytes(0, size - 1);
            repeat ($urandom_range(3)) send(8'($urandom_range(255)), 1'b0);
         end else if (sel < 85) begin
            size = $urandom_range(4, 40);
            build_region(size);
            write_region_length(16'(size));
            split = $urandom_range(1, size - 1);
            send_region_bytes(0, split - 1);
            write_region_length(16'($urandom_range(size + 4)));
            send_region_bytes(split, size - 1);
         end else begin
            case ($urandom_range(2))
               0:       write_region_length(16'd0);
               1:       write_region_length(16'hffff);
               default: write_region_length(16'($urandom_range(40)));
            endcase
            count = $urandom_range(1, 20);
            for (int i = 0; i < count; i++)
               send(8'($urandom_range(255)), i == 0 || $urandom_range(7) == 0);
         end
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

@@ der_tlv_header_parser.f @@
design/dtlv_pkg.sv
design/dtlv_req_if.sv
design/dtlv_rsp_if.sv
design/dtlv_in_stage.sv
design/dtlv_parse_core.sv
design/dtlv_out_stage.sv
design/der_tlv_header_parser.sv
verif/testbench.sv
